// File: rtl/button_event_qualifier_macros.svh
// assertion macros for the button event qualifier
// used by rtl modules that assert
`ifndef BUTTON_EVENT_QUALIFIER_MACROS_SVH
`define BUTTON_EVENT_QUALIFIER_MACROS_SVH
`define BEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BEQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`endif

// File: rtl/beq_pkg.sv
// shared constants and types for the button event qualifier
// no dependencies
`default_nettype none
package beq_pkg;
  localparam int unsigned Buttons = 5;
  localparam int unsigned IdxW = $clog2(Buttons);
  localparam int unsigned NumFeat = 5;

  typedef enum logic [2:0] {
    REG_FEATURE = 3'd0,
    REG_DEBOUNCE = 3'd1,
    REG_LONG = 3'd2,
    REG_DOUBLE = 3'd3,
    REG_RPT_DELAY = 3'd4,
    REG_RPT_PERIOD = 3'd5,
    REG_CHORD_HOLD = 3'd6,
    REG_CHORD_PAIR = 3'd7
  } reg_idx_e;

  // per-button record held in memory
  typedef struct packed {
    logic        raw_level;
    logic        stable_level;
    logic [31:0] last_change;
    logic [31:0] press_start;
    logic [31:0] next_repeat;
    logic        long_done;
    logic        click_pending;
    logic [31:0] release_time;
    logic        skip_release;
  } btn_rec_t;

  typedef struct packed {
    logic [19:0] feature;
    logic [15:0] debounce;
    logic [15:0] long_press;
    logic [15:0] dbl;
    logic [15:0] rpt_delay;
    logic [15:0] rpt_period;
  } cfg_t;

  typedef struct packed {
    logic click;
    logic dbl;
    logic lng;
    logic rpt;
  } btn_ev_t;
endpackage
`default_nettype wire

// File: rtl/button_event_qualifier.sv
// a poll request walks all Buttons = 5 buttons in turn before its result is given
// (each button gets a read state, S_READ, then a write-back state, S_WORK)
// a new poll is not taken while the walk is in progress
// the result waits in an output register; a new poll is taken once it is taken
// reset: all buttons released, times zero, registers at defaults, no clearing pass
// top level of the button event qualifier; depends on beq_pkg, beq_btn_update and the macros header
`default_nettype none
module button_event_qualifier import beq_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // now_ms, raw_pressed
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // click, double, long, repeat, chord_long, any
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [19:0] cfg_data_i
);
  typedef enum logic [1:0] {S_IDLE, S_READ, S_WORK} state_e;
  state_e state_q;
  cfg_t cfg_q;
  logic [15:0] hold_q;
  logic [5:0] pair_q;
  logic [31:0] now_q;
  logic [Buttons-1:0] raw_q, mem_valid_q;
  logic [IdxW-1:0] idx_q;
  logic chord_act_q, chord_fired_q, chord_ev_q;
  logic [31:0] chord_start_q;
  logic [Buttons-1:0] blk_q, setskip_q;
  logic [NumFeat-1:0] mc_q, md_q, ml_q, mr_q;
  btn_rec_t mem_q [Buttons];
  btn_rec_t rd_q, rd, wr;
  btn_ev_t ev;
  logic [2:0] ca, cb;
  logic c_en, c_both, c_fire;
  logic [Buttons-1:0] pair_mask;
  logic out_v_q;
  logic last;

  assign ca = pair_q[2:0];
  assign cb = pair_q[5:3];
  assign c_en = 32'(ca) < Buttons && 32'(cb) < Buttons;
  assign c_both = raw_q[IdxW'(ca)] && raw_q[IdxW'(cb)];
  assign pair_mask = (Buttons'(1) << ca) | (Buttons'(1) << cb);
  assign c_fire = c_en && c_both && chord_act_q && !chord_fired_q &&
                  (now_q - chord_start_q) >= {16'd0, hold_q};
  assign last = 32'(idx_q) == Buttons - 1;
  assign rd = mem_valid_q[idx_q] ? rd_q : '0;
  assign s_axis_tready = state_q == S_IDLE && !out_v_q;
  assign m_axis_tvalid = out_v_q;

  beq_btn_update u_upd (
    .clk_i, .rst_ni, .rec_i(rd), .cfg_i(cfg_q), .now_i(now_q), .raw_i(raw_q[idx_q]),
    .idx_i(idx_q), .blocked_i(blk_q[idx_q]), .set_skip_i(setskip_q[idx_q]),
    .rec_o(wr), .ev_o(ev)
  );

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[idx_q];
    if (state_q == S_WORK) mem_q[idx_q] <= wr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cfg_q <= {20'd130179, 16'd30, 16'd800, 16'd300, 16'd500, 16'd150};
      hold_q <= 16'd2000;
      pair_q <= 6'd8;
      mem_valid_q <= '0;
      idx_q <= '0;
      chord_act_q <= 1'b0;
      chord_fired_q <= 1'b0;
      chord_start_q <= '0;
      out_v_q <= 1'b0;
      now_q <= '0;
      raw_q <= '0;
      blk_q <= '0;
      setskip_q <= '0;
      chord_ev_q <= 1'b0;
      {mc_q, md_q, ml_q, mr_q} <= '0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_FEATURE:    cfg_q.feature <= cfg_data_i;
          REG_DEBOUNCE:   cfg_q.debounce <= cfg_data_i[15:0];
          REG_LONG:       cfg_q.long_press <= cfg_data_i[15:0];
          REG_DOUBLE:     cfg_q.dbl <= cfg_data_i[15:0];
          REG_RPT_DELAY:  cfg_q.rpt_delay <= cfg_data_i[15:0];
          REG_RPT_PERIOD: cfg_q.rpt_period <= cfg_data_i[15:0];
          REG_CHORD_HOLD: hold_q <= cfg_data_i[15:0];
          REG_CHORD_PAIR: pair_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            now_q <= s_axis_tdata[31:0];
            raw_q <= s_axis_tdata[32 +: Buttons];
            idx_q <= '0;
            {mc_q, md_q, ml_q, mr_q} <= '0;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          // chord state advances once per poll, before the first button
          if (idx_q == '0) begin
            blk_q <= (c_en && c_both) ? pair_mask : '0;
            setskip_q <= c_fire ? pair_mask : '0;
            chord_ev_q <= c_fire;
            if (c_en) begin
              if (c_both) begin
                if (!chord_act_q) begin
                  chord_act_q <= 1'b1;
                  chord_fired_q <= 1'b0;
                  chord_start_q <= now_q;
                end else if (c_fire) begin
                  chord_fired_q <= 1'b1;
                end
              end else begin
                chord_act_q <= 1'b0;
                chord_fired_q <= 1'b0;
              end
            end
          end
          state_q <= S_WORK;
        end
        S_WORK: begin
          mem_valid_q[idx_q] <= 1'b1;
          if (32'(idx_q) < NumFeat) begin
            mc_q[3'(idx_q)] <= ev.click;
            md_q[3'(idx_q)] <= ev.dbl;
            ml_q[3'(idx_q)] <= ev.lng;
            mr_q[3'(idx_q)] <= ev.rpt;
          end
          if (last) begin
            state_q <= S_IDLE;
            out_v_q <= 1'b1;
          end else begin
            idx_q <= idx_q + 1'b1;
            state_q <= S_READ;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {2'b00, |{mc_q, md_q, ml_q, mr_q, chord_ev_q}, chord_ev_q,
                         mr_q, ml_q, md_q, mc_q};

  `include "button_event_qualifier_macros.svh"
  `BEQ_ASSERT(a_no_take_busy, (state_q != S_IDLE) |-> !s_axis_tready, "request taken while busy")
  `BEQ_ASSERT(a_out_after_last, $rose(out_v_q) |-> $past(state_q) == S_WORK, "stray result")
  `BEQ_ASSERT_RST(a_rst_idle, !rst_ni |=> state_q == S_IDLE || !rst_ni, "not idle after reset")
endmodule
`default_nettype wire

// File: rtl/beq_btn_update.sv
// per-button read-modify-write logic: debounce, click, double click, long and repeat
// depends on beq_pkg and the macros header
`default_nettype none
module beq_btn_update import beq_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire btn_rec_t        rec_i,
  input  wire cfg_t            cfg_i,
  input  wire logic [31:0]     now_i,
  input  wire logic            raw_i,
  input  wire logic [IdxW-1:0] idx_i,
  input  wire logic            blocked_i,
  input  wire logic            set_skip_i,
  output btn_rec_t             rec_o,
  output btn_ev_t              ev_o
);
  logic fc, fd, fl, fr;
  btn_rec_t r;
  logic [31:0] dur, d;
  logic in_range;

  always_comb begin
    in_range = 32'(idx_i) < NumFeat;
    fc = in_range && cfg_i.feature[5'(idx_i)];
    fd = in_range && cfg_i.feature[5'd5 + 5'(idx_i)];
    fl = in_range && cfg_i.feature[5'd10 + 5'(idx_i)];
    fr = in_range && cfg_i.feature[5'd15 + 5'(idx_i)];
    r = rec_i;
    ev_o = '0;
    dur = '0;
    d = '0;
    if (set_skip_i) r.skip_release = 1'b1;
    if (raw_i != r.raw_level) begin
      r.raw_level = raw_i;
      r.last_change = now_i;
    end
    if ((now_i - r.last_change) >= {16'd0, cfg_i.debounce} &&
        r.stable_level != r.raw_level) begin
      r.stable_level = r.raw_level;
      if (r.stable_level) begin
        r.press_start = now_i;
        r.next_repeat = now_i + {16'd0, cfg_i.rpt_delay};
        r.long_done = 1'b0;
      end else begin
        dur = now_i - r.press_start;
        if (r.skip_release) begin
          r.skip_release = 1'b0;
          r.click_pending = 1'b0;
        end else if (!r.long_done && dur >= {16'd0, cfg_i.debounce} &&
                     dur < {16'd0, cfg_i.long_press}) begin
          if (fd && cfg_i.dbl != '0) begin
            if (!r.click_pending) begin
              r.click_pending = 1'b1;
              r.release_time = now_i;
            end else if ((now_i - r.release_time) <= {16'd0, cfg_i.dbl}) begin
              r.click_pending = 1'b0;
              ev_o.dbl = 1'b1;
            end else begin
              ev_o.click = fc;
              r.release_time = now_i;
            end
          end else begin
            ev_o.click = fc;
          end
        end
      end
    end
    if (r.stable_level && !r.skip_release) begin
      if (!r.long_done && fl && (now_i - r.press_start) >= {16'd0, cfg_i.long_press}) begin
        r.long_done = 1'b1;
        ev_o.lng = 1'b1;
      end
      d = now_i - r.next_repeat;
      if (fr && cfg_i.rpt_period != '0 && !d[31]) begin
        r.next_repeat = r.next_repeat + {16'd0, cfg_i.rpt_period};
        ev_o.rpt = 1'b1;
      end
    end
    if (cfg_i.dbl != '0 && r.click_pending && !r.skip_release &&
        (now_i - r.release_time) > {16'd0, cfg_i.dbl}) begin
      r.click_pending = 1'b0;
      ev_o.click = ev_o.click | fc;
    end
    if (blocked_i) ev_o = '0;
    ev_o.dbl = ev_o.dbl & fd;
    rec_o = r;
  end

  `include "button_event_qualifier_macros.svh"
  `BEQ_ASSERT(a_no_ev_blocked, blocked_i |-> ev_o == '0, "event on blocked button")
  `BEQ_ASSERT(a_long_sets_done, ev_o.lng |-> rec_o.long_done, "long without done")
  `BEQ_ASSERT(a_dbl_clears, ev_o.dbl |-> !rec_o.click_pending, "double left pending")
endmodule
`default_nettype wire
